// ===== sv/zpws_pkg.sv =====
package zpws_pkg;

    // Map geometry defaults and field widths.
    localparam int MAX_SIDE_DEFAULT = 64;
    localparam int ZONE_W           = 3;
    localparam int POS_W            = 6;
    localparam int SIDE_CFG_W       = 7;
    localparam int SIDE_W           = 9;
    localparam int COORD_W          = 10;
    localparam int PROX_W           = 16;
    localparam int WIN_IDX_W        = 3;

    localparam logic [SIDE_CFG_W-1:0] SIDE_CFG_RESET = 7'd64;
    localparam logic [WIN_IDX_W-1:0]  WIN_LAST       = 3'd4;
    localparam logic [WIN_IDX_W-1:0]  WIN_CENTER     = 3'd2;
    localparam logic [PROX_W-1:0]     PROX_MAX       = 16'd38944;

    // Request kinds.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Weight 1/(1+sqrt(d2)) in unsigned Q4.12, indexed by squared distance.
    localparam logic [PROX_W-1:0] WEIGHT_BY_D2 [9] = '{
        16'd4096, 16'd2048, 16'd1697, 16'd0, 16'd1365,
        16'd1266, 16'd0,    16'd0,    16'd1070
    };

    typedef struct packed {
        logic              req_type;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [ZONE_W-1:0] zone;
    } req_t;

    typedef struct packed {
        logic [PROX_W-1:0] proximity;
        logic              was_query;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Distance of a window index from the center, as a magnitude.
    function automatic logic [1:0] win_dist(input logic [WIN_IDX_W-1:0] idx);
        logic [WIN_IDX_W-1:0] d;
        d = (idx >= WIN_CENTER) ? (idx - WIN_CENTER) : (WIN_CENTER - idx);
        return d[1:0];
    endfunction

    // Weight for one window position.
    function automatic logic [PROX_W-1:0] win_weight(input logic [1:0] dist_r,
                                                     input logic [1:0] dist_c);
        logic [3:0] d2;
        d2 = 4'(dist_r) * 4'(dist_r) + 4'(dist_c) * 4'(dist_c);
        return WEIGHT_BY_D2[d2];
    endfunction

endpackage

// ===== sv/zpws_ram.sv =====
module zpws_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== sv/zpws_engine.sv =====
module zpws_engine #(
    parameter int MAX_SIDE = zpws_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [zpws_pkg::SIDE_W-1:0]            side,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  zpws_pkg::req_t                         s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output zpws_pkg::rsp_t                         m_data,
    output logic                                   ram_we,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   ram_addr,
    output logic [zpws_pkg::ZONE_W-1:0]            ram_wdata,
    input  logic [zpws_pkg::ZONE_W-1:0]            ram_rdata
);
    import zpws_pkg::*;

    localparam int AddrW     = $clog2(MAX_SIDE*MAX_SIDE);
    localparam int AddrCalcW = AddrW + 2;

    state_t state_reg, state_next;

    req_t                 req_reg, req_next;
    logic [WIN_IDX_W-1:0] dr_idx_reg, dr_idx_next;
    logic [WIN_IDX_W-1:0] dc_idx_reg, dc_idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [PROX_W-1:0]    pend_weight_reg, pend_weight_next;
    logic [PROX_W-1:0]    acc_reg, acc_next;
    logic                 m_valid_reg, m_valid_next;
    rsp_t                 m_data_reg, m_data_next;

    logic                    accept;
    logic                    out_free;
    logic                    out_load;
    logic                    scan_last;
    logic signed [COORD_W-1:0] off_r, off_c;
    logic signed [COORD_W-1:0] coord_r, coord_c;
    logic                    in_grid;
    logic [AddrCalcW-1:0]    addr_full;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_last = (dr_idx_reg == WIN_LAST) && (dc_idx_reg == WIN_LAST);

    // Cell coordinate: window offset while scanning, the cell itself on a write.
    always_comb begin
        if (state_reg == ST_SCAN) begin
            off_r = $signed(COORD_W'(dr_idx_reg)) - $signed(COORD_W'(WIN_CENTER));
            off_c = $signed(COORD_W'(dc_idx_reg)) - $signed(COORD_W'(WIN_CENTER));
        end else begin
            off_r = '0;
            off_c = '0;
        end
        coord_r = $signed(COORD_W'(req_reg.row)) + off_r;
        coord_c = $signed(COORD_W'(req_reg.col)) + off_c;
    end

    // Grid check and map address.
    assign in_grid = (coord_r >= 0) && (coord_r < $signed(COORD_W'(side))) &&
                     (coord_c >= 0) && (coord_c < $signed(COORD_W'(side)));
    assign addr_full = AddrCalcW'(coord_r[7:0]) * AddrCalcW'(MAX_SIDE)
                     + AddrCalcW'(coord_c[7:0]);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_data.req_type == REQ_QUERY) ? ST_SCAN : ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        s_ready  = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:  s_ready  = 1'b1;
            ST_WRITE: ram_we   = in_grid;
            ST_SCAN:  s_ready  = 1'b0;
            ST_DONE:  out_load = out_free;
            default:  s_ready  = 1'b0;
        endcase
    end

    assign ram_addr  = AddrW'(addr_full);
    assign ram_wdata = req_reg.zone;

    // Window counters, read pipeline stage and accumulator.
    always_comb begin
        req_next         = req_reg;
        dr_idx_next      = dr_idx_reg;
        dc_idx_next      = dc_idx_reg;
        pend_valid_next  = 1'b0;
        pend_weight_next = pend_weight_reg;
        acc_next         = acc_reg;

        // Add the weight of the neighbor whose map entry just came back, if its zone matches.
        if (pend_valid_reg && (ram_rdata == req_reg.zone)) begin
            acc_next = acc_reg + pend_weight_reg;
        end

        if (accept) begin
            req_next    = s_data;
            dr_idx_next = '0;
            dc_idx_next = '0;
            acc_next    = '0;
        end

        if (state_reg == ST_SCAN) begin
            pend_valid_next  = in_grid;
            pend_weight_next = win_weight(win_dist(dr_idx_reg), win_dist(dc_idx_reg));
            if (dr_idx_reg == WIN_LAST) begin
                dr_idx_next = '0;
                dc_idx_next = dc_idx_reg + 1'b1;
            end else begin
                dr_idx_next = dr_idx_reg + 1'b1;
            end
        end
    end

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next          = 1'b1;
            m_data_next.proximity = acc_next;
            m_data_next.was_query = req_reg.req_type;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            dr_idx_reg     <= '0;
            dc_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            acc_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            dr_idx_reg     <= dr_idx_next;
            dc_idx_reg     <= dc_idx_next;
            pend_valid_reg <= pend_valid_next;
            acc_reg        <= acc_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg         <= req_next;
        pend_weight_reg <= pend_weight_next;
        m_data_reg      <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The running sum stays within the largest possible window total.
    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= PROX_MAX)
        else $error("proximity sum out of range");

    // A pending map read only follows a scan cycle.
    a_pend_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> $past(state_reg) == ST_SCAN)
        else $error("pending read without scan");

    // A write acknowledge always carries zero proximity.
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.was_query) |-> m_data_reg.proximity == '0)
        else $error("write acknowledge with nonzero proximity");

    // The map is never written while a query scan is running.
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_DONE) |-> !ram_we)
        else $error("map write during scan");

    // The scan walks all 25 positions and then hands off to the result stage.
    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && scan_last) |=> state_reg == ST_DONE && pend_valid_reg == $past(in_grid))
        else $error("scan did not finish cleanly");

endmodule

// ===== sv/zone_proximity_window_sum.sv =====
// Channel   | Direction | Handshake         | Beat
// ----------+-----------+-------------------+-------------------------------
// s_        | in        | s_valid / s_ready | req_t: req_type, row, col, zone
// m_        | out       | m_valid / m_ready | rsp_t: proximity, was_query
// cfg_      | in        | cfg_we only       | grid_cells_per_side, 7 bits
//
// A query is accepted, then makes 25 map reads through the single
// map port (one window cell each), then adds the last cell and loads m_.
// A write is accepted, then writes the map, then loads m_.
// A new beat is accepted once the engine is idle, even while a result waits on m_.
// Reset is synchronous on aresetn; the side register returns to 64, the map is not cleared.
// A stalled result holds in the output register and the engine waits before loading the next.
module zone_proximity_window_sum #(
    parameter int MAX_SIDE = zpws_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [zpws_pkg::SIDE_CFG_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  zpws_pkg::req_t                    s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output zpws_pkg::rsp_t                    m_data
);
    import zpws_pkg::*;

    localparam int Depth = MAX_SIDE * MAX_SIDE;
    localparam int AddrW = $clog2(Depth);

    logic [SIDE_CFG_W-1:0] side_cfg_reg, side_cfg_next;
    logic [SIDE_W-1:0]     side;
    logic                  ram_we;
    logic [AddrW-1:0]      ram_addr;
    logic [ZONE_W-1:0]     ram_wdata;
    logic [ZONE_W-1:0]     ram_rdata;

    // Side length register.
    assign side_cfg_next = cfg_we ? cfg_wdata : side_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_cfg_reg <= SIDE_CFG_RESET;
        end else begin
            side_cfg_reg <= side_cfg_next;
        end
    end

    // A side above the map size acts as the map size.
    assign side = (SIDE_W'(side_cfg_reg) > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                              : SIDE_W'(side_cfg_reg);

    zpws_engine #(
        .MAX_SIDE (MAX_SIDE)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .side      (side),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    zpws_ram #(
        .WIDTH (ZONE_W),
        .DEPTH (Depth)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule
